FILE: sv/tsp_pkg.sv
// ---------------------------------------------------------------------------
// tsp_pkg
// Shared widths, codes and types for the tensor shard planner.
// ---------------------------------------------------------------------------
package tsp_pkg;

    localparam int W_TYPE  = 2;
    localparam int W_DIM   = 21;
    localparam int W_EXP   = 9;
    localparam int W_BLK   = 9;
    localparam int W_CNT   = 7;
    localparam int W_RANK  = 6;
    localparam int W_ROWS  = 29;
    localparam int W_BYTES = 56;
    localparam int W_DIVK  = 16;  // rank_count * block_elems
    localparam int W_ROWB  = 30;  // bytes of one row
    localparam int W_P1    = 51;  // dim_rows * row bytes
    localparam int W_CFGI  = 1;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [W_CFGI-1:0] CFG_RANK_COUNT = 1'b0;
    localparam logic [W_CFGI-1:0] CFG_RANK_INDEX = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_ROWS    = 2'd1,
        MODE_EXPERTS = 2'd2,
        MODE_INNER   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [W_DIM-1:0]   ne0;
        logic [W_DIM-1:0]   ne1;
        logic [W_EXP-1:0]   ne2;
        logic [W_BLK-1:0]   blk;
        logic [W_BLK-1:0]   bb;
        logic [W_DIM-1:0]   numer;
        logic [W_CNT-1:0]   divb;
        logic [W_DIVK-1:0]  divk;
    } t_req;

    typedef struct packed {
        logic vld;
        t_req req;
    } t_qif;

endpackage

FILE: sv/tsp_div.sv
// ---------------------------------------------------------------------------
// tsp_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module tsp_div #(
    parameter int NW = 21,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    logic [DW-1:0] r_rem [1:NW];
    logic [NW-1:0] r_num [1:NW];
    logic [DW-1:0] r_den [1:NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++) begin : g_stg
            logic [DW-1:0] cur_rem;
            logic [NW-1:0] cur_num;
            logic [DW-1:0] cur_den;
            logic [DW:0]   t;

            if (s == 0) begin : g_first
                assign cur_rem = '0;
                assign cur_num = i_num;
                assign cur_den = i_den;
            end else begin : g_rest
                assign cur_rem = r_rem[s];
                assign cur_num = r_num[s];
                assign cur_den = r_den[s];
            end

            assign t = {cur_rem, cur_num[NW-1]};

            // numerator shifts out at the top, quotient bits fill from below
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s+1] <= cur_den;
                    if (t >= {1'b0, cur_den}) begin
                        r_rem[s+1] <= DW'(t - {1'b0, cur_den});
                        r_num[s+1] <= {cur_num[NW-2:0], 1'b1};
                    end else begin
                        r_rem[s+1] <= t[DW-1:0];
                        r_num[s+1] <= {cur_num[NW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_num[NW];
    assign o_rem = r_rem[NW];

endmodule

FILE: sv/tsp_front.sv
// ---------------------------------------------------------------------------
// tsp_front
// Accepts tensor descriptions, picks the split mode and divisors, and
// queues the classified request for the back end.
// ---------------------------------------------------------------------------
module tsp_front
    import tsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [W_TYPE-1:0] i_req_type,
    input  logic [W_DIM-1:0]  i_dim_inner,
    input  logic [W_DIM-1:0]  i_dim_rows,
    input  logic [W_EXP-1:0]  i_dim_experts,
    input  logic [W_BLK-1:0]  i_block_elems,
    input  logic [W_BLK-1:0]  i_block_bytes,
    input  logic [W_CNT-1:0]  i_rank_count,
    output t_qif              o_q,
    input  logic              i_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_req          req;
    t_mode         mode;
    t_req          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          push;
    logic          pop;

    always_comb begin
        if (i_rank_count <= W_CNT'(1) || i_req_type == W_TYPE'(MODE_NONE)) begin
            mode = MODE_NONE;
        end else begin
            mode = t_mode'(i_req_type);
        end
    end

    always_comb begin
        req.mode  = mode;
        req.ne0   = i_dim_inner;
        req.ne1   = i_dim_rows;
        req.ne2   = i_dim_experts;
        req.blk   = i_block_elems;
        req.bb    = i_block_bytes;
        req.divb  = i_rank_count;
        req.divk  = W_DIVK'(i_rank_count) * W_DIVK'(i_block_elems);
        case (mode)
            MODE_EXPERTS: req.numer = W_DIM'(i_dim_experts);
            MODE_INNER:   req.numer = i_dim_inner;
            default:      req.numer = i_dim_rows;
        endcase
    end

    assign o_stall = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(r_rp + 1'b1);
            end
            if (push && !pop) begin
                r_cnt <= (AW+1)'(r_cnt + 1'b1);
            end else if (pop && !push) begin
                r_cnt <= (AW+1)'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= req;
        end
    end

    assign o_q.vld = (r_cnt != '0);
    assign o_q.req = r_mem[r_rp];

endmodule

FILE: sv/tsp_back.sv
// ---------------------------------------------------------------------------
// tsp_back
// Divides, multiplies out the slice plan and holds the result for transfer.
// ---------------------------------------------------------------------------
module tsp_back
    import tsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_qif               i_q,
    output logic               o_pop,
    input  logic [W_RANK-1:0]  i_rank_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_plan_valid,
    output logic [W_DIM-1:0]   o_slice_inner,
    output logic [W_DIM-1:0]   o_slice_rows,
    output logic [W_EXP-1:0]   o_slice_experts,
    output logic [W_ROWS-1:0]  o_chunk_count,
    output logic [W_BYTES-1:0] o_chunk_size,
    output logic [W_BYTES-1:0] o_base_offset,
    output logic [W_BYTES-1:0] o_source_stride,
    output logic [W_BYTES-1:0] o_slice_size
);

    localparam int NW = W_DIM;

    logic adv;

    logic [NW-1:0]     qa, qb, qc;
    logic [W_CNT-1:0]  rem_b;
    logic [W_DIVK-1:0] rem_c;

    logic r_sv [1:NW];
    t_req r_si [1:NW];

    t_req itm;
    logic ok;

    // multiply stage 1
    logic             r1_vld, r1_ok;
    t_req             r1_itm;
    logic [NW-1:0]    r1_qb;
    logic [W_ROWB-1:0] r1_rb, r1_sb, r1_rows3;
    // multiply stage 2
    logic             r2_vld, r2_ok;
    t_req             r2_itm;
    logic [NW-1:0]    r2_qb;
    logic [W_ROWB-1:0] r2_rb, r2_sb, r2_rows3;
    logic [W_P1-1:0]  r2_p1, r2_chunk1;
    logic [W_BYTES-1:0] r2_total3;
    // multiply stage 3
    logic               r3_vld, r3_ok;
    t_mode              r3_mode;
    logic [W_DIM-1:0]   r3_s0, r3_s1;
    logic [W_EXP-1:0]   r3_s2;
    logic [W_ROWS-1:0]  r3_rows;
    logic [W_BYTES-1:0] r3_chunk, r3_stride, r3_total;

    logic [W_BYTES-1:0] chunk2, total1;
    logic [W_BYTES-1:0] n_chunk, n_stride, n_total;
    logic [W_ROWS-1:0]  n_rows;
    logic [W_BYTES-1:0] n_base;

    logic               r_out_vld;

    assign adv   = !r_out_vld || !i_stall;
    assign o_pop = adv;

    tsp_div #(.NW(NW), .DW(W_BLK)) u_div_row (
        .i_clk (i_clk), .i_en (adv),
        .i_num (i_q.req.ne0), .i_den (i_q.req.blk),
        .o_quo (qa), .o_rem ()
    );

    tsp_div #(.NW(NW), .DW(W_CNT)) u_div_rank (
        .i_clk (i_clk), .i_en (adv),
        .i_num (i_q.req.numer), .i_den (i_q.req.divb),
        .o_quo (qb), .o_rem (rem_b)
    );

    tsp_div #(.NW(NW), .DW(W_DIVK)) u_div_blk (
        .i_clk (i_clk), .i_en (adv),
        .i_num (i_q.req.ne0), .i_den (i_q.req.divk),
        .o_quo (qc), .o_rem (rem_c)
    );

    // side band follows the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NW; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (adv) begin
            r_sv[1] <= i_q.vld;
            for (int s = 2; s <= NW; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_si[1] <= i_q.req;
            for (int s = 2; s <= NW; s++) begin
                r_si[s] <= r_si[s-1];
            end
        end
    end

    assign itm = r_si[NW];

    always_comb begin
        case (itm.mode)
            MODE_NONE:    ok = 1'b1;
            MODE_ROWS:    ok = (rem_b == '0);
            MODE_EXPERTS: ok = (rem_b == '0);
            MODE_INNER:   ok = (itm.blk != '0) && (rem_c == '0);
            default:      ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r1_vld    <= r_sv[NW];
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_out_vld <= r3_vld;
        end
    end

    // stage 1: row bytes, sliced row bytes, rows of the contraction split
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ok    <= ok;
            r1_itm   <= itm;
            r1_qb    <= qb;
            r1_rb    <= (itm.blk == '0) ? '0 : W_ROWB'(qa) * W_ROWB'(itm.bb);
            r1_sb    <= (itm.blk == '0) ? '0 : W_ROWB'(qc) * W_ROWB'(itm.bb);
            r1_rows3 <= W_ROWB'(itm.ne1) * W_ROWB'(itm.ne2);
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_ok     <= r1_ok;
            r2_itm    <= r1_itm;
            r2_qb     <= r1_qb;
            r2_rb     <= r1_rb;
            r2_sb     <= r1_sb;
            r2_rows3  <= r1_rows3;
            r2_p1     <= W_P1'(r1_itm.ne1) * W_P1'(r1_rb);
            r2_chunk1 <= W_P1'(r1_qb) * W_P1'(r1_rb);
            r2_total3 <= W_BYTES'(r1_rows3) * W_BYTES'(r1_sb);
        end
    end

    // stage 3: expert chunk, row-split total, mode selection
    assign chunk2 = W_BYTES'(r2_qb[W_EXP-1:0]) * W_BYTES'(r2_p1);
    assign total1 = W_BYTES'(r2_itm.ne2) * W_BYTES'(r2_chunk1);

    always_comb begin
        case (r2_itm.mode)
            MODE_ROWS: begin
                n_rows   = W_ROWS'(r2_itm.ne2);
                n_chunk  = W_BYTES'(r2_chunk1);
                n_stride = W_BYTES'(r2_p1);
                n_total  = total1;
            end
            MODE_EXPERTS: begin
                n_rows   = W_ROWS'(1);
                n_chunk  = chunk2;
                n_stride = '0;
                n_total  = chunk2;
            end
            MODE_INNER: begin
                n_rows   = r2_rows3[W_ROWS-1:0];
                n_chunk  = W_BYTES'(r2_sb);
                n_stride = W_BYTES'(r2_rb);
                n_total  = r2_total3;
            end
            default: begin
                n_rows   = W_ROWS'(r2_itm.ne1);
                n_chunk  = W_BYTES'(r2_rb);
                n_stride = W_BYTES'(r2_rb);
                n_total  = W_BYTES'(r2_p1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_ok     <= r2_ok;
            r3_mode   <= r2_itm.mode;
            r3_s0     <= (r2_itm.mode == MODE_INNER) ? r2_qb : r2_itm.ne0;
            r3_s1     <= (r2_itm.mode == MODE_ROWS) ? r2_qb : r2_itm.ne1;
            r3_s2     <= (r2_itm.mode == MODE_EXPERTS) ? r2_qb[W_EXP-1:0] : r2_itm.ne2;
            r3_rows   <= n_rows;
            r3_chunk  <= n_chunk;
            r3_stride <= n_stride;
            r3_total  <= n_total;
        end
    end

    // output stage: this rank's offset, then a failed check zeroes everything
    assign n_base = (r3_mode == MODE_NONE) ? '0 : W_BYTES'(i_rank_index) * r3_chunk;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_plan_valid    <= r3_ok;
            o_slice_inner   <= r3_ok ? r3_s0     : '0;
            o_slice_rows    <= r3_ok ? r3_s1     : '0;
            o_slice_experts <= r3_ok ? r3_s2     : '0;
            o_chunk_count   <= r3_ok ? r3_rows   : '0;
            o_chunk_size    <= r3_ok ? r3_chunk  : '0;
            o_base_offset   <= r3_ok ? n_base    : '0;
            o_source_stride <= r3_ok ? r3_stride : '0;
            o_slice_size    <= r3_ok ? r3_total  : '0;
        end
    end

    assign o_valid = r_out_vld;

endmodule

FILE: sv/tensor_shard_plan_core.sv
// Requests pass a QUEUE_DEPTH-entry queue (2 by default), the dividers, the
// multiply stages and the output stage. Throughput: one descriptor per cycle
// while not stalled; the 21-stage dividers and three multiply stages pipeline fully.
// Reset: synchronous, active low; clears the queue and pipeline valids,
// rank_count returns to 1 and rank_index to 0. No clearing pass.
// ---------------------------------------------------------------------------
// tensor_shard_plan_core
// Per-rank slice plan for a quantized tensor split across parallel ranks.
// ---------------------------------------------------------------------------
module tensor_shard_plan_core
    import tsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [W_TYPE-1:0]  i_req_type,
    input  logic [W_DIM-1:0]   i_dim_inner,
    input  logic [W_DIM-1:0]   i_dim_rows,
    input  logic [W_EXP-1:0]   i_dim_experts,
    input  logic [W_BLK-1:0]   i_block_elems,
    input  logic [W_BLK-1:0]   i_block_bytes,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_plan_valid,
    output logic [W_DIM-1:0]   o_slice_inner,
    output logic [W_DIM-1:0]   o_slice_rows,
    output logic [W_EXP-1:0]   o_slice_experts,
    output logic [W_ROWS-1:0]  o_chunk_count,
    output logic [W_BYTES-1:0] o_chunk_size,
    output logic [W_BYTES-1:0] o_base_offset,
    output logic [W_BYTES-1:0] o_source_stride,
    output logic [W_BYTES-1:0] o_slice_size,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [W_CFGI-1:0]  i_cfg_index,
    input  logic [W_CNT-1:0]   i_cfg_data
);

    logic [W_CNT-1:0]  r_rank_count;
    logic [W_RANK-1:0] r_rank_index;
    t_qif              q;
    logic              pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_count <= W_CNT'(1);
            r_rank_index <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RANK_COUNT: r_rank_count <= i_cfg_data;
                CFG_RANK_INDEX: r_rank_index <= i_cfg_data[W_RANK-1:0];
                default: ;
            endcase
        end
    end

    tsp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_dim_inner   (i_dim_inner),
        .i_dim_rows    (i_dim_rows),
        .i_dim_experts (i_dim_experts),
        .i_block_elems (i_block_elems),
        .i_block_bytes (i_block_bytes),
        .i_rank_count  (r_rank_count),
        .o_q           (q),
        .i_pop         (pop)
    );

    tsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q             (q),
        .o_pop           (pop),
        .i_rank_index    (r_rank_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_plan_valid    (o_plan_valid),
        .o_slice_inner   (o_slice_inner),
        .o_slice_rows    (o_slice_rows),
        .o_slice_experts (o_slice_experts),
        .o_chunk_count   (o_chunk_count),
        .o_chunk_size    (o_chunk_size),
        .o_base_offset   (o_base_offset),
        .o_source_stride (o_source_stride),
        .o_slice_size    (o_slice_size)
    );

endmodule

FILE: sv/tsp_chk.sv
// ---------------------------------------------------------------------------
// tsp_chk
// Port-level checks for the tensor shard planner.
// ---------------------------------------------------------------------------
module tsp_chk
    import tsp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_plan_valid,
    input logic [W_DIM-1:0]   o_slice_inner,
    input logic [W_ROWS-1:0]  o_chunk_count,
    input logic [W_BYTES-1:0] o_chunk_size,
    input logic [W_BYTES-1:0] o_base_offset,
    input logic [W_BYTES-1:0] o_slice_size
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_base_offset))
        else $error("stalled result dropped or changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_plan_valid |-> o_slice_inner == '0 && o_chunk_count == '0
            && o_chunk_size == '0 && o_base_offset == '0 && o_slice_size == '0)
        else $error("failed plan carries nonzero fields");

    a_one_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chunk_count == W_ROWS'(1) && o_plan_valid
            |-> o_slice_size == o_chunk_size)
        else $error("single chunk total mismatch");

endmodule

bind tensor_shard_plan_core tsp_chk u_tsp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_plan_valid    (o_plan_valid),
    .o_slice_inner   (o_slice_inner),
    .o_chunk_count   (o_chunk_count),
    .o_chunk_size    (o_chunk_size),
    .o_base_offset   (o_base_offset),
    .o_slice_size    (o_slice_size)
);
